@@ src/rgba_pixel_pack_unpack_defines.svh @@
// ----------------------------------------------------------------------------
// RGBA pixel pack/unpack assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGBA_PIXEL_PACK_UNPACK_DEFINES_SVH
`define RGBA_PIXEL_PACK_UNPACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rppu_pkg.sv @@
// ----------------------------------------------------------------------------
// RGBA pixel pack/unpack package
// Transaction types, operation codes, reset layout and channel expansion.
// ----------------------------------------------------------------------------
package rppu_pkg;

    localparam int NUM_CHAN = 4;
    localparam int PIX_W    = 32;
    localparam int CHAN_W   = 8;
    localparam int SHIFT_W  = 5;
    localparam int WIDTH_W  = 6;
    localparam int IDX_W    = 2;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_PACK_RGBA = 2'd0;
    localparam logic [1:0] KIND_UNPACK    = 2'd1;
    localparam logic [1:0] KIND_PACK_RGB  = 2'd2;

    // Register indexes and lane numbers.
    localparam logic [IDX_W-1:0] REG_RED   = 2'd0;
    localparam logic [IDX_W-1:0] REG_GREEN = 2'd1;
    localparam logic [IDX_W-1:0] REG_BLUE  = 2'd2;
    localparam logic [IDX_W-1:0] REG_ALPHA = 2'd3;

    localparam logic [PIX_W-1:0] RESET_MASK [NUM_CHAN] = '{
        32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000
    };

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
        logic [PIX_W-1:0]  pixel_in;
    } rgba_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_out;
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
    } rgba_out_t;

    // Decoded layout of one channel: position of the field and its length.
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [WIDTH_W-1:0] width;
    } chan_cfg_t;

    typedef struct packed {
        logic pack_en;
        logic unpack_en;
    } lane_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0]  field;
        logic [CHAN_W-1:0] chan;
        logic              absent;
    } lane_res_t;

    // Expands a field narrower than 8 bits to full scale, v * 255 / (2^w - 1).
    // The quotient comes from a multiply by ceil(2^24 / (2^w - 1)) and a shift;
    // over the 15-bit range of v * 255 the excess stays below 1 / (2^w - 1),
    // so the truncated product equals the floor of the exact quotient.
    function automatic logic [CHAN_W-1:0] expand_narrow(input logic [2:0] w,
                                                        input logic [6:0] v);
        logic [14:0] p;
        logic [24:0] m;
        logic [39:0] prod;
        begin
            p = {v, 8'd0} - {8'd0, v};
            case (w)
                3'd1:    m = 25'd16777216;
                3'd2:    m = 25'd5592406;
                3'd3:    m = 25'd2396746;
                3'd4:    m = 25'd1118482;
                3'd5:    m = 25'd541201;
                3'd6:    m = 25'd266306;
                3'd7:    m = 25'd132105;
                default: m = 25'd0;
            endcase
            prod = 40'(p) * 40'(m);
            return prod[24 +: CHAN_W];
        end
    endfunction

endpackage

@@ src/rppu_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// RGBA pixel pack/unpack layout registers
// Decodes each written channel mask into a field shift and width and holds it.
// ----------------------------------------------------------------------------
module rppu_cfg_regs
    import rppu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_index,
    input  logic [PIX_W-1:0]    wr_data,
    output chan_cfg_t           chan_cfg [NUM_CHAN]
);

    logic [SHIFT_W-1:0] dec_shift;
    logic [WIDTH_W-1:0] dec_width;
    logic [PIX_W-1:0]   run;

    // Shift is the lowest set bit; width is the run of ones starting there.
    always_comb
    begin
        dec_shift = '0;
        for (int i = PIX_W - 1; i >= 0; i--)
        begin
            if (wr_data[i])
            begin
                dec_shift = SHIFT_W'(i);
            end
        end
        run = wr_data >> dec_shift;
        dec_width = WIDTH_W'(PIX_W);
        for (int i = PIX_W - 1; i >= 0; i--)
        begin
            if (!run[i])
            begin
                dec_width = WIDTH_W'(i);
            end
        end
    end

    function automatic chan_cfg_t reset_cfg(input logic [PIX_W-1:0] m);
        chan_cfg_t c;
        logic [PIX_W-1:0] r;
        begin
            c.shift = '0;
            for (int i = PIX_W - 1; i >= 0; i--)
            begin
                if (m[i])
                begin
                    c.shift = SHIFT_W'(i);
                end
            end
            r = m >> c.shift;
            c.width = WIDTH_W'(PIX_W);
            for (int i = PIX_W - 1; i >= 0; i--)
            begin
                if (!r[i])
                begin
                    c.width = WIDTH_W'(i);
                end
            end
            return c;
        end
    endfunction

    for (genvar g = 0; g < NUM_CHAN; g++)
    begin : g_chan
        chan_cfg_t cfg_reg;
        chan_cfg_t cfg_next;

        always_comb
        begin
            cfg_next = cfg_reg;
            if (wr_en && (wr_index == IDX_W'(g)))
            begin
                cfg_next.shift = dec_shift;
                cfg_next.width = dec_width;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cfg_reg <= reset_cfg(RESET_MASK[g]);
            end
            else
            begin
                cfg_reg <= cfg_next;
            end
        end

        assign chan_cfg[g] = cfg_reg;
    end

endmodule

@@ src/rppu_lane.sv @@
// ----------------------------------------------------------------------------
// RGBA pixel pack/unpack channel lane
// Scales one channel into its pixel field and expands that field back to 8 bits.
// ----------------------------------------------------------------------------
module rppu_lane
    import rppu_pkg::*;
(
    input  logic              clk,
    input  chan_cfg_t         cfg,
    input  lane_ctl_t         ctl,
    input  logic [CHAN_W-1:0] value,
    input  logic [PIX_W-1:0]  pixel,
    output lane_res_t         res
);

    localparam int EXT_W = PIX_W + CHAN_W;

    logic [EXT_W-1:0]   ext;
    logic [PIX_W-1:0]   scaled;
    logic [PIX_W-1:0]   placed;
    logic [PIX_W:0]     top_bit;
    logic [PIX_W-1:0]   fmask;
    logic [PIX_W-1:0]   fval;
    logic [PIX_W-1:0]   wide_val;
    logic [CHAN_W-1:0]  unpacked;
    logic               empty;
    lane_res_t          res_next;
    lane_res_t          res_reg;

    always_comb
    begin
        // value * 2^width / 256, then moved up to the field position.
        ext    = {{PIX_W{1'b0}}, value} << cfg.width;
        scaled = ext[EXT_W-1:CHAN_W];
        placed = scaled << cfg.shift;

        top_bit  = (PIX_W+1)'(1) << cfg.width;
        fmask    = top_bit[PIX_W-1:0] - PIX_W'(1);
        fval     = (pixel >> cfg.shift) & fmask;
        wide_val = fval >> (cfg.width - WIDTH_W'(CHAN_W));
        empty    = (cfg.width == '0);

        if (empty)
        begin
            unpacked = '0;
        end
        else if (cfg.width >= WIDTH_W'(CHAN_W))
        begin
            unpacked = wide_val[CHAN_W-1:0];
        end
        else
        begin
            unpacked = expand_narrow(cfg.width[2:0], fval[6:0]);
        end

        res_next.field  = ctl.pack_en ? placed : '0;
        res_next.chan   = ctl.unpack_en ? unpacked : '0;
        res_next.absent = ctl.unpack_en & empty;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

@@ src/rppu_merge.sv @@
// ----------------------------------------------------------------------------
// RGBA pixel pack/unpack merge stage
// Joins the lane fields into one pixel and forms the registered result.
// ----------------------------------------------------------------------------
module rppu_merge
    import rppu_pkg::*;
(
    input  logic      clk,
    input  lane_res_t lane [NUM_CHAN],
    output rgba_out_t result
);

    rgba_out_t out_next;
    rgba_out_t out_reg;

    always_comb
    begin
        out_next.pixel_out = lane[REG_RED].field | lane[REG_GREEN].field |
                             lane[REG_BLUE].field | lane[REG_ALPHA].field;
        out_next.red_out   = lane[REG_RED].chan;
        out_next.green_out = lane[REG_GREEN].chan;
        out_next.blue_out  = lane[REG_BLUE].chan;
        // A pixel without an alpha field unpacks as fully opaque.
        out_next.alpha_out = lane[REG_ALPHA].absent ? {CHAN_W{1'b1}}
                                                    : lane[REG_ALPHA].chan;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result = out_reg;

endmodule

@@ src/rgba_pixel_pack_unpack.sv @@
// ----------------------------------------------------------------------------
// RGBA pixel pack/unpack top level
// Converts between 8-bit RGBA channels and a mask-defined packed pixel.
// ----------------------------------------------------------------------------
// Each result passes the lane register and then the merge register before result_valid.
// Throughput: one transaction per cycle; busy stays low, four lanes run in parallel.
// Layout registers take effect for a transaction started the cycle after the write.
// Reset restores the default layout (alpha 31:24, red 23:16, green 15:8, blue 7:0).
// The receiver cannot stall; each result is shown for exactly one cycle.
module rgba_pixel_pack_unpack
    import rppu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rgba_in_t         in_item,
    output logic             result_valid,
    output rgba_out_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0] cfg_data
);

`include "rgba_pixel_pack_unpack_defines.svh"

    chan_cfg_t         chan_cfg [NUM_CHAN];
    lane_ctl_t         ctl [NUM_CHAN];
    lane_res_t         lane_res [NUM_CHAN];
    logic [CHAN_W-1:0] lane_value [NUM_CHAN];
    logic              accept;
    logic              pack_any;
    logic              v1_reg;
    logic              v1_next;
    logic              v2_reg;
    logic              v2_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    rppu_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .chan_cfg (chan_cfg)
    );

    assign pack_any = (in_item.kind == KIND_PACK_RGBA) || (in_item.kind == KIND_PACK_RGB);

    assign lane_value[REG_RED]   = in_item.red_in;
    assign lane_value[REG_GREEN] = in_item.green_in;
    assign lane_value[REG_BLUE]  = in_item.blue_in;
    assign lane_value[REG_ALPHA] = in_item.alpha_in;

    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            ctl[i].pack_en   = pack_any;
            ctl[i].unpack_en = (in_item.kind == KIND_UNPACK);
        end
        // Alpha is placed only by the full RGBA pack.
        ctl[REG_ALPHA].pack_en = (in_item.kind == KIND_PACK_RGBA);
    end

    for (genvar g = 0; g < NUM_CHAN; g++)
    begin : g_lane
        rppu_lane u_lane (
            .clk   (clk),
            .cfg   (chan_cfg[g]),
            .ctl   (ctl[g]),
            .value (lane_value[g]),
            .pixel (in_item.pixel_in),
            .res   (lane_res[g])
        );
    end

    rppu_merge u_merge (
        .clk    (clk),
        .lane   (lane_res),
        .result (result)
    );

    assign v1_next = accept;
    assign v2_next = v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    assign result_valid = v2_reg;

    `RPPU_ASSERT_NEXT(a_start_enters_lanes, accept, v1_reg, "accepted transaction lost in lanes")
    `RPPU_ASSERT_NOW(a_result_has_source, result_valid, $past(accept, 2), "result without transaction")
    `RPPU_ASSERT_NOW(a_unpack_no_pixel,
        result_valid && $past(accept && (in_item.kind == KIND_UNPACK), 2),
        result.pixel_out == '0, "unpack transaction produced pixel bits")
    `RPPU_ASSERT_NOW(a_pack_no_channels,
        result_valid && $past(accept && (in_item.kind != KIND_UNPACK), 2),
        (result.red_out == '0) && (result.alpha_out == '0),
        "pack transaction produced channel values")

endmodule
